[src/rwgq_pkg.sv]
// Shared types and codes for the reader/writer grant queue.
// Used by rwgq_ctrl, rwgq_dp and reader_writer_grant_queue_top.
`timescale 1ns / 1ps

package rwgq_pkg;

  localparam int DEF_QUEUE_DEPTH = 16;
  localparam int DEF_STAMP_BITS  = 31;
  localparam int DEF_TAG_BITS    = 16;

  localparam int CMD_W       = 3;
  localparam int KIND_W      = 3;
  localparam int MODE_W      = 2;
  localparam int READER_BITS = 16;

  localparam logic [READER_BITS-1:0] READER_MAX = '1;

  // commands
  localparam logic [CMD_W-1:0] CMD_UNRIG_REQ = 3'd0;
  localparam logic [CMD_W-1:0] CMD_READ_REQ  = 3'd1;
  localparam logic [CMD_W-1:0] CMD_WRITE_REQ = 3'd2;
  localparam logic [CMD_W-1:0] CMD_READ_REL  = 3'd3;
  localparam logic [CMD_W-1:0] CMD_WRITE_REL = 3'd4;

  // access modes
  localparam logic [MODE_W-1:0] MODE_UNRIG = 2'd0;
  localparam logic [MODE_W-1:0] MODE_READ  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_WRITE = 2'd2;

  // holder state
  localparam logic [1:0] HOLD_IDLE  = 2'd0;
  localparam logic [1:0] HOLD_READ  = 2'd1;
  localparam logic [1:0] HOLD_WRITE = 2'd2;

  // result kinds
  localparam logic [KIND_W-1:0] KIND_DISPATCH = 3'd0;
  localparam logic [KIND_W-1:0] KIND_QUEUED   = 3'd1;
  localparam logic [KIND_W-1:0] KIND_DROPPED  = 3'd2;
  localparam logic [KIND_W-1:0] KIND_RELEASED = 3'd3;
  localparam logic [KIND_W-1:0] KIND_ERROR    = 3'd4;

  // controller -> datapath
  typedef struct packed {
    logic load;
    logic exec;
    logic drain;
  } ctrl_t;

  // datapath -> controller
  typedef struct packed {
    logic out_free;
    logic go_drain;
    logic drain_more;
  } stat_t;

endpackage

[src/rwgq_ctrl.sv]
// Sequencing state machine for the grant queue.
// Depends on rwgq_pkg; drives rwgq_dp through ctrl_t, reads stat_t.
`timescale 1ns / 1ps

module rwgq_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            s_tvalid,
  output logic            s_tready,
  output rwgq_pkg::ctrl_t ctrl,
  input  rwgq_pkg::stat_t stat
);
  import rwgq_pkg::*;

  localparam logic [1:0] ST_IDLE     = 2'd0;
  localparam logic [1:0] ST_EXEC     = 2'd1;
  localparam logic [1:0] ST_DRAIN    = 2'd2;
  localparam logic [1:0] ST_DRAIN_RD = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;

  always_comb begin
    state_next = state;
    s_tready   = 1'b0;
    ctrl       = '0;
    case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          ctrl.load  = 1'b1;
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (stat.out_free) begin
          ctrl.exec  = 1'b1;
          state_next = stat.go_drain ? ST_DRAIN : ST_IDLE;
        end
      end
      ST_DRAIN: begin
        if (stat.out_free) begin
          ctrl.drain = 1'b1;
          state_next = stat.drain_more ? ST_DRAIN_RD : ST_IDLE;
        end
      end
      // head moved: wait in ST_DRAIN_RD for the queue read to catch up
      ST_DRAIN_RD: state_next = ST_DRAIN;
      default:     state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

[src/rwgq_dp.sv]
// Datapath: holder state, reader count, stamp, wait queue memory,
// pending drain result and output register. Depends on rwgq_pkg.
`timescale 1ns / 1ps

module rwgq_dp #(
  parameter int QUEUE_DEPTH = rwgq_pkg::DEF_QUEUE_DEPTH,
  parameter int STAMP_BITS  = rwgq_pkg::DEF_STAMP_BITS,
  parameter int TAG_BITS    = rwgq_pkg::DEF_TAG_BITS
) (
  input  logic                               clk,
  input  logic                               rst,
  input  rwgq_pkg::ctrl_t                    ctrl,
  output rwgq_pkg::stat_t                    stat,
  input  logic [rwgq_pkg::CMD_W-1:0]         in_cmd,
  input  logic [STAMP_BITS-1:0]              in_stamp,
  input  logic [TAG_BITS-1:0]                in_tag,
  input  logic                               out_ready,
  output logic                               out_valid,
  output logic [rwgq_pkg::KIND_W-1:0]        out_kind,
  output logic [TAG_BITS-1:0]                out_tag,
  output logic [rwgq_pkg::MODE_W-1:0]        out_mode,
  output logic                               out_copy,
  output logic [STAMP_BITS-1:0]              out_stamp,
  output logic [$clog2(QUEUE_DEPTH+1)-1:0]   out_wait,
  output logic                               out_last
);
  import rwgq_pkg::*;

  localparam int HW      = $clog2(QUEUE_DEPTH);
  localparam int FW      = $clog2(QUEUE_DEPTH + 1);
  localparam int ENTRY_W = STAMP_BITS + TAG_BITS + MODE_W;

  // latched input item
  logic [CMD_W-1:0]      cmd_q;
  logic [STAMP_BITS-1:0] stamp_q;
  logic [TAG_BITS-1:0]   tag_q;

  logic [1:0]             holder, holder_next;
  logic [READER_BITS-1:0] reader_count, count_next;
  logic [STAMP_BITS-1:0]  version, version_next;
  logic [HW-1:0]          head, head_next;
  logic [FW-1:0]          fill, fill_next;

  logic [ENTRY_W-1:0] mem [QUEUE_DEPTH];
  logic [ENTRY_W-1:0] rd_q;

  logic                pend_valid;
  logic [TAG_BITS-1:0] pend_tag;
  logic [MODE_W-1:0]   pend_mode;
  logic                pend_copy;

  logic [STAMP_BITS-1:0] rd_stamp;
  logic [TAG_BITS-1:0]   rd_tag;
  logic [MODE_W-1:0]     rd_mode;
  logic [MODE_W-1:0]     req_mode;
  logic [HW:0]           tail_sum;
  logic [HW-1:0]         tail;
  logic [HW-1:0]         head_inc;
  logic fill_zero, fill_full, head_write, read_ok, req_grant, ent_grant, is_req;
  logic rel_read_ok, rel_write_ok, rel_idle;

  logic              wr_en, pend_set, emit;
  logic [KIND_W-1:0] e_kind;
  logic [TAG_BITS-1:0] e_tag;
  logic [MODE_W-1:0] e_mode;
  logic              e_copy, e_last;
  logic [FW-1:0]     e_wait;

  assign rd_stamp = rd_q[ENTRY_W-1 -: STAMP_BITS];
  assign rd_tag   = rd_q[MODE_W +: TAG_BITS];
  assign rd_mode  = rd_q[MODE_W-1:0];
  assign req_mode = cmd_q[MODE_W-1:0];

  assign fill_zero  = (fill == '0);
  assign fill_full  = (fill == FW'(QUEUE_DEPTH));
  assign head_write = !fill_zero && (rd_mode == MODE_WRITE);
  assign read_ok    = (reader_count != READER_MAX) &&
                      (holder == HOLD_IDLE || holder == HOLD_READ);

  assign req_grant = (cmd_q == CMD_UNRIG_REQ) ||
                     (cmd_q == CMD_READ_REQ && !head_write && read_ok) ||
                     (cmd_q == CMD_WRITE_REQ && holder == HOLD_IDLE);
  // a drained head is never blocked by itself
  assign ent_grant = (rd_mode == MODE_UNRIG) ||
                     (rd_mode == MODE_READ && read_ok) ||
                     (rd_mode == MODE_WRITE && holder == HOLD_IDLE);
  assign is_req       = (cmd_q == CMD_UNRIG_REQ) || (cmd_q == CMD_READ_REQ) ||
                        (cmd_q == CMD_WRITE_REQ);
  assign rel_read_ok  = (cmd_q == CMD_READ_REL) && (reader_count != '0) &&
                        (holder == HOLD_READ);
  assign rel_write_ok = (cmd_q == CMD_WRITE_REL) && (holder == HOLD_WRITE);
  assign rel_idle     = rel_write_ok ||
                        (rel_read_ok && reader_count == READER_BITS'(1));

  assign stat.go_drain   = rel_idle && !fill_zero;
  assign stat.drain_more = !fill_zero && ent_grant;
  assign stat.out_free   = !out_valid || out_ready;

  assign tail_sum = (HW+1)'(head) + (HW+1)'(fill);
  assign tail     = (tail_sum >= (HW+1)'(QUEUE_DEPTH)) ?
                    HW'(tail_sum - (HW+1)'(QUEUE_DEPTH)) : tail_sum[HW-1:0];
  assign head_inc = (head == HW'(QUEUE_DEPTH - 1)) ? '0 : head + 1'b1;

  always_comb begin
    holder_next  = holder;
    count_next   = reader_count;
    version_next = version;
    head_next    = head;
    fill_next    = fill;
    wr_en        = 1'b0;
    pend_set     = 1'b0;
    emit         = 1'b0;
    e_kind       = KIND_RELEASED;
    e_tag        = '0;
    e_mode       = MODE_UNRIG;
    e_copy       = 1'b0;
    e_last       = 1'b1;
    e_wait       = fill;
    if (ctrl.exec) begin
      if (is_req) begin
        emit = 1'b1;
        if (req_grant) begin
          if (cmd_q == CMD_READ_REQ) begin
            count_next  = reader_count + 1'b1;
            holder_next = HOLD_READ;
          end else if (cmd_q == CMD_WRITE_REQ) begin
            holder_next = HOLD_WRITE;
          end
          e_kind = KIND_DISPATCH;
          e_tag  = tag_q;
          e_mode = req_mode;
          e_copy = (stamp_q != version);
        end else if (!fill_full) begin
          wr_en     = 1'b1;
          fill_next = fill + 1'b1;
          e_kind    = KIND_QUEUED;
          e_tag     = tag_q;
          e_mode    = req_mode;
        end else begin
          e_kind = KIND_DROPPED;
          e_tag  = tag_q;
          e_mode = req_mode;
        end
      end else if (cmd_q == CMD_READ_REL || cmd_q == CMD_WRITE_REL) begin
        if (!rel_read_ok && !rel_write_ok) begin
          emit   = 1'b1;
          e_kind = KIND_ERROR;
        end else begin
          if (rel_read_ok) begin
            count_next = reader_count - 1'b1;
          end else begin
            version_next = version + 1'b1;
          end
          if (rel_idle) begin
            holder_next = HOLD_IDLE;
          end
          // when the queue drains, results come from the drain steps
          emit = !stat.go_drain;
        end
      end else begin
        emit = 1'b1;
      end
      e_wait = fill_next;
    end else if (ctrl.drain) begin
      if (stat.drain_more) begin
        if (rd_mode == MODE_READ) begin
          count_next  = reader_count + 1'b1;
          holder_next = HOLD_READ;
        end else if (rd_mode == MODE_WRITE) begin
          holder_next = HOLD_WRITE;
        end
        head_next = head_inc;
        fill_next = fill - 1'b1;
        pend_set  = 1'b1;
        // previous grant is not the last one: send it now
        emit   = pend_valid;
        e_last = 1'b0;
      end else begin
        emit = 1'b1;
      end
      if (pend_valid) begin
        e_kind = KIND_DISPATCH;
        e_tag  = pend_tag;
        e_mode = pend_mode;
        e_copy = pend_copy;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      cmd_q   <= in_cmd;
      stamp_q <= in_stamp;
      tag_q   <= in_tag;
    end
    if (wr_en) begin
      mem[tail] <= {stamp_q, tag_q, req_mode};
    end
    rd_q <= mem[head];
    if (pend_set) begin
      pend_tag  <= rd_tag;
      pend_mode <= rd_mode;
      pend_copy <= (rd_stamp != version);
    end
    if (emit) begin
      out_kind  <= e_kind;
      out_tag   <= e_tag;
      out_mode  <= e_mode;
      out_copy  <= e_copy;
      out_stamp <= version_next;
      out_wait  <= e_wait;
      out_last  <= e_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      holder       <= HOLD_IDLE;
      reader_count <= '0;
      version      <= '0;
      head         <= '0;
      fill         <= '0;
      pend_valid   <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      holder       <= holder_next;
      reader_count <= count_next;
      version      <= version_next;
      head         <= head_next;
      fill         <= fill_next;
      if (ctrl.exec) begin
        pend_valid <= 1'b0;
      end else if (pend_set) begin
        pend_valid <= 1'b1;
      end
      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

[src/reader_writer_grant_queue_top.sv]
// Reader/writer grant queue for one shared object.
// Slave stream: s_tuser carries the command, s_tdata the request stamp and
// job tag. Master stream: one or more results per item, m_tuser the result
// kind, m_tlast marks the final result of an item.
// A request (unrigorous, read, write) is taken into the input register in
// the idle state; the execute state then decides it and loads the result
// into the output register once that register is free.
// A release that leaves the object idle drains the wait queue in order
// until an entry is refused; every drained entry takes a queue memory read,
// then a grant, and the final result takes one more drain step. Each drained
// result is held back one step until it is known whether it is the last.
// One item is in work at a time; s_tready is high only between items. The
// next item may be accepted while the last result still waits in the
// output register. If m_tready stays low the block holds its result and
// stops before loading the next one.
// Reset (rst, synchronous) empties the queue, clears holder, reader count
// and stamp; no clearing pass is needed.
// Depends on rwgq_pkg, rwgq_ctrl and rwgq_dp.
`timescale 1ns / 1ps

module reader_writer_grant_queue_top #(
  parameter int QUEUE_DEPTH = rwgq_pkg::DEF_QUEUE_DEPTH,
  parameter int STAMP_BITS  = rwgq_pkg::DEF_STAMP_BITS,
  parameter int TAG_BITS    = rwgq_pkg::DEF_TAG_BITS
) (
  input  logic clk,
  input  logic rst,
  input  logic s_tvalid,
  output logic s_tready,
  // request_stamp, job_tag
  input  logic [((STAMP_BITS + TAG_BITS + 7) / 8) * 8 - 1:0] s_tdata,
  // command
  input  logic [rwgq_pkg::CMD_W-1:0] s_tuser,
  output logic m_tvalid,
  input  logic m_tready,
  // out_tag, out_mode, copy_needed, current_stamp, waiting_count
  output logic [((TAG_BITS + rwgq_pkg::MODE_W + 1 + STAMP_BITS +
                  $clog2(QUEUE_DEPTH + 1) + 7) / 8) * 8 - 1:0] m_tdata,
  // kind
  output logic [rwgq_pkg::KIND_W-1:0] m_tuser,
  output logic m_tlast
);
  import rwgq_pkg::*;

  localparam int FW       = $clog2(QUEUE_DEPTH + 1);
  localparam int OUT_W    = ((TAG_BITS + MODE_W + 1 + STAMP_BITS + FW + 7) / 8) * 8;
  localparam int COPY_POS = TAG_BITS + MODE_W;
  localparam int WAIT_LSB = TAG_BITS + MODE_W + 1 + STAMP_BITS;

  ctrl_t ctrl;
  stat_t stat;

  logic [TAG_BITS-1:0]   out_tag;
  logic [MODE_W-1:0]     out_mode;
  logic                  out_copy;
  logic [STAMP_BITS-1:0] out_stamp;
  logic [FW-1:0]         out_wait;

  rwgq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .ctrl     (ctrl),
    .stat     (stat)
  );

  rwgq_dp #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .STAMP_BITS  (STAMP_BITS),
    .TAG_BITS    (TAG_BITS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (ctrl),
    .stat      (stat),
    .in_cmd    (s_tuser),
    .in_stamp  (s_tdata[STAMP_BITS-1:0]),
    .in_tag    (s_tdata[STAMP_BITS +: TAG_BITS]),
    .out_ready (m_tready),
    .out_valid (m_tvalid),
    .out_kind  (m_tuser),
    .out_tag   (out_tag),
    .out_mode  (out_mode),
    .out_copy  (out_copy),
    .out_stamp (out_stamp),
    .out_wait  (out_wait),
    .out_last  (m_tlast)
  );

  assign m_tdata = OUT_W'({out_wait, out_stamp, out_copy, out_mode, out_tag});

`ifndef SYNTHESIS
  // one item in work at a time
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("item accepted while previous one in work");

  a_copy_only_dispatch: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser != KIND_DISPATCH) |-> !m_tdata[COPY_POS])
    else $error("copy flag set on a result that dispatches nothing");

  a_release_clean: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && (m_tuser == KIND_RELEASED || m_tuser == KIND_ERROR)) |->
    (m_tdata[COPY_POS-1:0] == '0))
    else $error("release result carries tag or mode");

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[WAIT_LSB +: FW] <= FW'(QUEUE_DEPTH)))
    else $error("waiting count beyond queue depth");
`endif

endmodule

[verif/reader_writer_grant_queue_top_tb.sv]
// Self-checking bench for reader_writer_grant_queue_top: directed and random requests
// and releases, every item predicted on acceptance and results compared in order.
// Depends on rwgq_pkg and the block's RTL only.
`timescale 1ns / 1ps

module reader_writer_grant_queue_top_tb;
  import rwgq_pkg::*;

  localparam int QDEPTH  = DEF_QUEUE_DEPTH;
  localparam int STAMP_W = DEF_STAMP_BITS;
  localparam int TAG_W   = DEF_TAG_BITS;
  localparam int CNT_W   = $clog2(QDEPTH + 1);
  localparam int SD_W    = ((STAMP_W + TAG_W + 7) / 8) * 8;
  localparam int MD_W    = ((TAG_W + MODE_W + 1 + STAMP_W + CNT_W + 7) / 8) * 8;
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int PHASE_ITEMS = 40;

  // commands the package leaves unnamed
  localparam logic [CMD_W-1:0] CMD_UNRIG_REL = 3'd5;
  localparam logic [CMD_W-1:0] CMD_SPARE_6   = 3'd6;
  localparam logic [CMD_W-1:0] CMD_SPARE_7   = 3'd7;

  typedef struct {
    logic [CMD_W-1:0]   cmd;
    logic [STAMP_W-1:0] stamp;
    logic [TAG_W-1:0]   tag;
  } request_t;

  typedef struct {
    logic [KIND_W-1:0]  kind;
    logic [TAG_W-1:0]   tag;
    logic [MODE_W-1:0]  mode;
    logic               copy;
    logic [STAMP_W-1:0] stamp;
    logic [CNT_W-1:0]   waiting;
    logic               last;
  } outcome_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [SD_W-1:0] s_tdata = '0;    // request_stamp, job_tag
  logic [CMD_W-1:0] s_tuser = '0;   // command
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [MD_W-1:0] m_tdata;         // out_tag, out_mode, copy_needed, current_stamp, waiting_count
  logic [KIND_W-1:0] m_tuser;       // kind
  logic m_tlast;

  reader_writer_grant_queue_top i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // shadow of the arbiter
  logic [1:0]             hold_st = HOLD_IDLE;
  logic [READER_BITS-1:0] readers = '0;
  logic [STAMP_W-1:0]     obj_stamp = '0;
  logic [STAMP_W-1:0]     wq_stamp [QDEPTH];
  logic [TAG_W-1:0]       wq_tag [QDEPTH];
  logic [MODE_W-1:0]      wq_mode [QDEPTH];
  int                     wq_head = 0;
  int                     wq_fill = 0;

  request_t requests_todo[$];
  outcome_t outcomes_due[$];
  request_t in_flight;
  bit       req_taken = 1'b0;
  bit       hold_sender = 1'b0;
  int       tx_gap_pct = 8;
  int       rx_stall_pct = 55;
  int       cycle_count = 0;
  int       failures = 0;
  int       items_taken = 0;
  int       results_seen = 0;
  int       kind_seen [5] = '{default: 0};
  int       peak_readers = 0;

  function automatic bit take_object(logic [MODE_W-1:0] mode, bit head_wr);
    if (mode == MODE_UNRIG) return 1'b1;
    if (mode == MODE_READ) begin
      if (head_wr || readers == READER_MAX) return 1'b0;
      if (hold_st != HOLD_IDLE && hold_st != HOLD_READ) return 1'b0;
      readers = readers + 1'b1;
      hold_st = HOLD_READ;
      if (readers > peak_readers) peak_readers = readers;
      return 1'b1;
    end
    if (mode == MODE_WRITE && hold_st == HOLD_IDLE) begin
      hold_st = HOLD_WRITE;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic void post_outcome(logic [KIND_W-1:0] kind, logic [TAG_W-1:0] tag,
                                       logic [MODE_W-1:0] mode, logic copy);
    outcome_t o;
    o.kind    = kind;
    o.tag     = tag;
    o.mode    = mode;
    o.copy    = copy;
    o.stamp   = obj_stamp;
    o.waiting = wq_fill[CNT_W-1:0];
    o.last    = 1'b0;
    outcomes_due = {outcomes_due, o};
  endfunction

  // once idle, grant queued entries in order until one is refused
  function automatic int drain_waiters();
    int n;
    int h;
    logic [MODE_W-1:0] m;
    n = 0;
    while (wq_fill > 0 && n < QDEPTH) begin
      h = wq_head;
      m = wq_mode[h];
      if (!take_object(m, 1'b0)) break;
      wq_head = (h + 1) % QDEPTH;
      wq_fill--;
      post_outcome(KIND_DISPATCH, wq_tag[h], m, wq_stamp[h] != obj_stamp);
      n++;
    end
    return n;
  endfunction

  function automatic void arbiter_step(request_t rq);
    int n;
    int slot;
    bit head_wr;
    logic [MODE_W-1:0] m;
    n = 1;
    m = rq.cmd[MODE_W-1:0];
    if (rq.cmd <= CMD_WRITE_REQ) begin
      head_wr = wq_fill > 0 && wq_mode[wq_head] == MODE_WRITE;
      if (take_object(m, head_wr)) begin
        post_outcome(KIND_DISPATCH, rq.tag, m, rq.stamp != obj_stamp);
      end else if (wq_fill < QDEPTH) begin
        slot = (wq_head + wq_fill) % QDEPTH;
        wq_stamp[slot] = rq.stamp;
        wq_tag[slot]   = rq.tag;
        wq_mode[slot]  = m;
        wq_fill++;
        post_outcome(KIND_QUEUED, rq.tag, m, 1'b0);
      end else begin
        post_outcome(KIND_DROPPED, rq.tag, m, 1'b0);
      end
    end else if (rq.cmd == CMD_READ_REL) begin
      if (readers == 0 || hold_st != HOLD_READ) begin
        post_outcome(KIND_ERROR, '0, MODE_UNRIG, 1'b0);
      end else begin
        n = 0;
        readers = readers - 1'b1;
        if (readers == 0) begin
          hold_st = HOLD_IDLE;
          n = drain_waiters();
        end
        if (n == 0) begin
          post_outcome(KIND_RELEASED, '0, MODE_UNRIG, 1'b0);
        end
      end
    end else if (rq.cmd == CMD_WRITE_REL) begin
      if (hold_st != HOLD_WRITE) begin
        post_outcome(KIND_ERROR, '0, MODE_UNRIG, 1'b0);
      end else begin
        obj_stamp = obj_stamp + 1'b1;   // wraps at the stamp width
        hold_st = HOLD_IDLE;
        if (drain_waiters() == 0) begin
          post_outcome(KIND_RELEASED, '0, MODE_UNRIG, 1'b0);
        end
      end
    end else begin
      post_outcome(KIND_RELEASED, '0, MODE_UNRIG, 1'b0);
    end
    outcomes_due[outcomes_due.size() - 1].last = 1'b1;
  endfunction

  function automatic void check_field(string name, longint unsigned want, longint unsigned got);
    if (want != got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      failures++;
    end
  endfunction

  // driver: offers the next item at the falling edge
  always @(negedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= rx_stall_pct);
      if (!s_tvalid || req_taken) begin
        req_taken = 1'b0;
        if (!hold_sender && requests_todo.size() > 0 && $urandom_range(99) >= tx_gap_pct) begin
          in_flight = requests_todo[0];
          requests_todo.delete(0);
          s_tdata  <= SD_W'({in_flight.tag, in_flight.stamp});
          s_tuser  <= in_flight.cmd;
          s_tvalid <= 1'b1;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // monitor: predicts on acceptance, checks results in order
  always @(posedge clk) begin
    outcome_t want;
    if (!rst) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
        $display("Timeout after %0d cycles", cycle_count);
        $display("Simulation FAILED");
        $finish;
      end else begin
        if (s_tvalid && s_tready) begin
          arbiter_step(in_flight);
          req_taken = 1'b1;
          items_taken++;
        end
        if (m_tvalid && m_tready) begin
          results_seen++;
          if (outcomes_due.size() == 0) begin
            $error("unexpected result: kind %0d tag 0x%0h", m_tuser, m_tdata[TAG_W-1:0]);
            failures++;
          end else begin
            want = outcomes_due[0];
            outcomes_due.delete(0);
            if (want.kind < 5) kind_seen[want.kind]++;
            check_field("kind", want.kind, m_tuser);
            check_field("out_tag", want.tag, m_tdata[TAG_W-1:0]);
            check_field("out_mode", want.mode, m_tdata[TAG_W +: MODE_W]);
            check_field("copy_needed", want.copy, m_tdata[TAG_W + MODE_W]);
            check_field("current_stamp", want.stamp, m_tdata[TAG_W + MODE_W + 1 +: STAMP_W]);
            check_field("waiting_count", want.waiting,
                        m_tdata[TAG_W + MODE_W + 1 + STAMP_W +: CNT_W]);
            check_field("last", want.last, m_tlast);
          end
        end
      end
    end
  end

  task automatic queue_request(logic [CMD_W-1:0] cmd, logic [STAMP_W-1:0] stamp,
                               logic [TAG_W-1:0] tag);
    request_t rq;
    rq.cmd   = cmd;
    rq.stamp = stamp;
    rq.tag   = tag;
    requests_todo = {requests_todo, rq};
  endtask

  // hold the sender back until every item is in and every result is out
  task automatic hold_until_drained();
    while (requests_todo.size() > 0) @(posedge clk);
    hold_sender = 1'b1;
    while (s_tvalid || outcomes_due.size() > 0) @(posedge clk);
    hold_sender = 1'b0;
  endtask

  task automatic queue_random_request();
    int r;
    logic [CMD_W-1:0]   cmd;
    logic [STAMP_W-1:0] stamp;
    logic [TAG_W-1:0]   tag;
    r = $urandom_range(99);
    if (r < 10)      cmd = CMD_UNRIG_REQ;
    else if (r < 35) cmd = CMD_READ_REQ;
    else if (r < 52) cmd = CMD_WRITE_REQ;
    else if (r < 78) begin
      // release that matches the current holder, so the queue gets drained
      if (hold_st == HOLD_WRITE)     cmd = CMD_WRITE_REL;
      else if (hold_st == HOLD_READ) cmd = CMD_READ_REL;
      else                           cmd = $urandom_range(1) ? CMD_READ_REL : CMD_WRITE_REL;
    end
    else if (r < 88) cmd = CMD_READ_REL;
    else if (r < 95) cmd = CMD_WRITE_REL;
    else if (r < 97) cmd = CMD_UNRIG_REL;
    else             cmd = $urandom_range(1) ? CMD_SPARE_6 : CMD_SPARE_7;
    r = $urandom_range(99);
    if (r < 35)      stamp = obj_stamp;
    else if (r < 50) stamp = obj_stamp - 1'b1;
    else if (r < 60) stamp = STAMP_W'($urandom_range(7));
    else             stamp = STAMP_W'($urandom());
    r = $urandom_range(99);
    if (r < 5)       tag = '0;
    else if (r < 10) tag = '1;
    else             tag = TAG_W'($urandom());
    queue_request(cmd, stamp, tag);
  endtask

  initial begin
    logic [MODE_W-1:0] m;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: field extremes, errors, filling the wait queue to overflow
    queue_request(CMD_UNRIG_REQ, '0, '0);
    queue_request(CMD_UNRIG_REQ, '1, '1);
    queue_request(CMD_READ_REL, '0, '0);      // release at zero count
    queue_request(CMD_WRITE_REL, '0, '0);     // write release while not writing
    queue_request(CMD_UNRIG_REL, '1, '1);
    queue_request(CMD_SPARE_6, '0, '1);
    queue_request(CMD_SPARE_7, '1, '0);
    queue_request(CMD_WRITE_REQ, '0, TAG_W'(1));
    for (int i = 0; i < QDEPTH; i++) begin
      m = (i == 2 || i == 9) ? MODE_WRITE : MODE_READ;
      queue_request(CMD_W'(m), STAMP_W'(i % 2), TAG_W'($urandom()));
    end
    queue_request(CMD_READ_REQ, '0, TAG_W'($urandom()));   // queue full: dropped
    queue_request(CMD_UNRIG_REQ, '0, TAG_W'($urandom()));  // granted even while writing
    queue_request(CMD_WRITE_REL, '0, '0);                   // drains two reads, stops at write
    queue_request(CMD_READ_REQ, STAMP_W'(1), TAG_W'($urandom())); // head is a write
    queue_request(CMD_READ_REL, '0, '0);
    queue_request(CMD_READ_REL, '0, '0);

    for (int phase = 0; phase < 3; phase++) begin
      tx_gap_pct   = (phase == 0) ? 8 : (phase == 1) ? 55 : 0;
      rx_stall_pct = (phase == 0) ? 55 : (phase == 1) ? 8 : 0;
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        while (requests_todo.size() >= 2) @(posedge clk);
        queue_random_request();
        if (i == PHASE_ITEMS / 2) hold_until_drained();
      end
    end

    // release the object so the run ends idle
    hold_until_drained();
    while (hold_st != HOLD_IDLE) begin
      queue_request((hold_st == HOLD_WRITE) ? CMD_WRITE_REL : CMD_READ_REL, '0, '0);
      hold_until_drained();
    end

    while (requests_todo.size() > 0 || s_tvalid) @(posedge clk);
    while (outcomes_due.size() > 0) @(posedge clk);
    repeat (2 + 2 * QDEPTH + 8) @(posedge clk);

    if (outcomes_due.size() != 0) begin
      $error("%0d results never arrived", outcomes_due.size());
      failures++;
    end
    $display("Covered %0d items and %0d results: %0d dispatched, %0d queued, %0d dropped,",
             items_taken, results_seen, kind_seen[KIND_DISPATCH], kind_seen[KIND_QUEUED],
             kind_seen[KIND_DROPPED]);
    $display("  %0d plain releases, %0d release errors, peak reader count %0d",
             kind_seen[KIND_RELEASED], kind_seen[KIND_ERROR], peak_readers);
    if (failures == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

[filelist.f]
src/rwgq_pkg.sv
src/rwgq_ctrl.sv
src/rwgq_dp.sv
src/reader_writer_grant_queue_top.sv
verif/reader_writer_grant_queue_top_tb.sv
